@@ src/srb_pkg.sv @@
// Shared constants, field widths and state type of the sequence reorder buffer.
package srb_pkg;

    localparam int Capacity    = 16;
    localparam int PayloadBits = 32;

    localparam int SeqW     = 16;
    localparam int PayloadW = 32;
    localparam int CreditW  = 8;
    localparam int LimitW   = 5;
    localparam int FreeW    = 5;

    // Input beat: seq_number, payload, deliver_credit; output beat: out_seq_number,
    // out_payload, request_more, dropped, free_slots, then zero fill.
    localparam int InDataW  = 56;
    localparam int OutDataW = 56;
    localparam int CreditLo = SeqW + PayloadW;
    localparam int ReqBit   = SeqW + PayloadW;
    localparam int DropBit  = ReqBit + 1;
    localparam int FreeLo   = DropBit + 1;

    localparam logic [LimitW-1:0] LimitReset = 5'd16;

    localparam int CmdDepth = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RELEASE,
        ST_DECIDE,
        ST_READ,
        ST_EMIT
    } back_state_t;

endpackage

@@ src/sequence_reorder_buffer.sv @@
// An item without flush is stored in ST_CHECK, after the back end pops its command from
// the command queue into cmd_reg. A flushing item then releases its run of in-order
// entries into the output queue, one release per cycle, and delivers each beat through
// the output queue port, read in ST_READ and offered in ST_EMIT when the output is free.
// A two-entry command queue lets further beats be taken while results are delivered.
// Reset (aresetn low, synchronous) clears the valid bits, counters and expected number
// at once, and loads the limit register with 16; there is no clearing pass.
module sequence_reorder_buffer #(
    parameter int CAPACITY     = srb_pkg::Capacity,
    parameter int PAYLOAD_BITS = srb_pkg::PayloadBits
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [srb_pkg::LimitW-1:0]   cfg_data,   // store_limit
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [srb_pkg::InDataW-1:0]  s_tdata,    // seq_number, payload, deliver_credit
    input  logic                         s_tlast,    // flush
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_seq_number, out_payload, request_more, dropped, free_slots, zero fill
    output logic [srb_pkg::OutDataW-1:0] m_tdata,
    output logic                         m_tuser,    // has_item
    output logic                         m_tlast     // last
);

    localparam int CntW  = $clog2(CAPACITY + 1);
    localparam int DataW = (PAYLOAD_BITS < srb_pkg::PayloadW) ? PAYLOAD_BITS
                                                               : srb_pkg::PayloadW;
    localparam int CmdW  = srb_pkg::SeqW + DataW + 2 * CntW + 1;

    logic            cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic [CmdW-1:0] cmd_in, cmd_out;

    srb_front #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .CMD_W        (CmdW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd_data  (cmd_in)
    );

    srb_cmd_fifo #(
        .WIDTH (CmdW)
    ) u_cmd_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (cmd_push),
        .din     (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .dout    (cmd_out),
        .empty   (cmd_empty)
    );

    srb_back #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .CMD_W        (CmdW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ src/srb_front.sv @@
// Front end: limit register, input beat decoding and command build.
module srb_front #(
    parameter int CAPACITY     = srb_pkg::Capacity,
    parameter int PAYLOAD_BITS = srb_pkg::PayloadBits,
    parameter int CMD_W        = 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [srb_pkg::LimitW-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [srb_pkg::InDataW-1:0]     s_tdata,
    input  logic                            s_tlast,
    input  logic                            cmd_full,
    output logic                            cmd_push,
    output logic [CMD_W-1:0]                cmd_data
);

    localparam int CntW  = $clog2(CAPACITY + 1);
    localparam int DataW = (PAYLOAD_BITS < srb_pkg::PayloadW) ? PAYLOAD_BITS
                                                               : srb_pkg::PayloadW;

    logic [srb_pkg::LimitW-1:0]  limit_reg;
    logic [CntW-1:0]             eff_limit;
    logic [CntW-1:0]             n_req;
    logic [srb_pkg::CreditW-1:0] credit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= srb_pkg::LimitReset;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign credit    = s_tdata[srb_pkg::CreditLo +: srb_pkg::CreditW];

    // A limit of zero behaves as one, and anything above the capacity as the capacity.
    always_comb begin
        if (limit_reg == '0) begin
            eff_limit = CntW'(1);
        end else if (int'(limit_reg) > CAPACITY) begin
            eff_limit = CntW'(CAPACITY);
        end else begin
            eff_limit = CntW'(limit_reg);
        end
        if (int'(credit) < int'(eff_limit)) begin
            n_req = CntW'(credit);
        end else begin
            n_req = eff_limit;
        end
    end

    assign s_tready = !cmd_full;
    assign cmd_push = s_tvalid && !cmd_full;
    assign cmd_data = {s_tlast, eff_limit, n_req,
                       s_tdata[srb_pkg::SeqW +: DataW], s_tdata[srb_pkg::SeqW-1:0]};

endmodule

@@ src/srb_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
module srb_cmd_fifo #(
    parameter int WIDTH = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PtrW = $clog2(srb_pkg::CmdDepth);
    localparam int CntW = $clog2(srb_pkg::CmdDepth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(srb_pkg::CmdDepth - 1);

    logic [WIDTH-1:0] cmd_mem [srb_pkg::CmdDepth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CntW'(srb_pkg::CmdDepth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = cmd_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            cmd_mem[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ src/srb_back.sv @@
// Back end: reorder store, in-order release into the output queue and delivery.
module srb_back #(
    parameter int CAPACITY     = srb_pkg::Capacity,
    parameter int PAYLOAD_BITS = srb_pkg::PayloadBits,
    parameter int CMD_W        = 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_empty,
    input  logic [CMD_W-1:0]             cmd_data,
    output logic                         cmd_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [srb_pkg::OutDataW-1:0] m_tdata,
    output logic                         m_tuser,
    output logic                         m_tlast
);

    localparam int CntW  = $clog2(CAPACITY + 1);
    localparam int IdxW  = $clog2(CAPACITY);
    localparam int DataW = (PAYLOAD_BITS < srb_pkg::PayloadW) ? PAYLOAD_BITS
                                                               : srb_pkg::PayloadW;
    localparam int EntW  = srb_pkg::SeqW + DataW;
    localparam int SeqW  = srb_pkg::SeqW;
    localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

    srb_pkg::back_state_t state_reg, state_next;

    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [SeqW-1:0]     c_seq;
    logic [DataW-1:0]    c_data;
    logic [CntW-1:0]     c_nreq, c_lim;
    logic                c_flush;

    logic [EntW-1:0]     store_mem [CAPACITY];
    logic [EntW-1:0]     queue_mem [CAPACITY];
    logic [EntW-1:0]     srd_reg, qrd_reg;

    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [SeqW-1:0]     ne_reg, ne_next;
    logic [IdxW-1:0]     ne_slot_reg, ne_slot_next;
    logic [CntW-1:0]     pend_reg, pend_next;
    logic [CntW-1:0]     oc_reg, oc_next;
    logic [CntW-1:0]     cnt_reg, cnt_next;
    logic [CntW-1:0]     fs_reg, fs_next;
    logic [IdxW-1:0]     head_reg, head_next;
    logic [IdxW-1:0]     mv_addr_reg, mv_addr_next;
    logic                mv_reg, mv_next;
    logic                drop_reg, drop_next;
    logic                rep_drop_reg, rep_drop_next;
    logic                req_reg, req_next;
    logic                item_reg, item_next;

    logic                          m_valid_reg, m_valid_next;
    logic [srb_pkg::OutDataW-1:0]  m_data_reg, m_data_next;
    logic                          m_user_reg, m_user_next;
    logic                          m_last_reg, m_last_next;

    logic                store_we, qrd_en;
    logic [SeqW-1:0]     gap;
    logic                far, wrapped, drop;
    logic [IdxW:0]       slot_sum, tail_sum, head_sum;
    logic [IdxW-1:0]     slot;
    logic [CntW:0]       used;
    logic [CntW-1:0]     free_sel;
    logic [CntW-1:0]     n_eff;
    logic                out_free, is_last;
    logic [SeqW-1:0]     q_seq;
    logic [DataW-1:0]    q_data;

    assign c_seq   = cmd_reg[SeqW-1:0];
    assign c_data  = cmd_reg[SeqW +: DataW];
    assign c_nreq  = cmd_reg[SeqW + DataW +: CntW];
    assign c_lim   = cmd_reg[SeqW + DataW + CntW +: CntW];
    assign c_flush = cmd_reg[CMD_W-1];

    assign q_seq  = qrd_reg[SeqW-1:0];
    assign q_data = qrd_reg[SeqW +: DataW];

    // The slot of an item is its number modulo the capacity. Inside the window it is
    // the expected slot plus the distance, except after a 16-bit wrap, where the
    // number itself is already below the capacity.
    assign gap      = c_seq - ne_reg;
    assign far      = (gap >= SeqW'(CAPACITY));
    assign wrapped  = (c_seq < ne_reg);
    assign slot_sum = {1'b0, ne_slot_reg} + (IdxW + 1)'(gap);
    always_comb begin
        if (wrapped) begin
            slot = IdxW'(c_seq);
        end else if (slot_sum >= (IdxW + 1)'(CAPACITY)) begin
            slot = IdxW'(slot_sum - (IdxW + 1)'(CAPACITY));
        end else begin
            slot = IdxW'(slot_sum);
        end
    end

    assign n_eff = (oc_reg == '0 || c_nreq == '0) ? '0 :
                   ((c_nreq < oc_reg) ? c_nreq : oc_reg);

    always_comb begin
        if (state_reg == srb_pkg::ST_DECIDE) begin
            used = (CntW + 1)'(pend_reg) + (CntW + 1)'(oc_reg) - (CntW + 1)'(n_eff);
        end else begin
            used = (CntW + 1)'(pend_reg) + (CntW + 1)'(oc_reg);
        end
        if (used >= (CntW + 1)'(c_lim)) begin
            free_sel = '0;
        end else begin
            free_sel = CntW'((CntW + 1)'(c_lim) - used);
        end
    end

    assign drop = far || valid_reg[slot] || (free_sel == '0);

    assign tail_sum = (IdxW + 1)'(head_reg) + (IdxW + 1)'(oc_reg);
    assign head_sum = (IdxW + 1)'(head_reg) + 1'b1;
    assign out_free = !m_valid_reg || m_tready;
    assign is_last  = !item_reg || (cnt_reg == '0);

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        valid_next    = valid_reg;
        ne_next       = ne_reg;
        ne_slot_next  = ne_slot_reg;
        pend_next     = pend_reg;
        oc_next       = oc_reg;
        cnt_next      = cnt_reg;
        fs_next       = fs_reg;
        head_next     = head_reg;
        mv_addr_next  = mv_addr_reg;
        mv_next       = 1'b0;
        drop_next     = drop_reg;
        rep_drop_next = rep_drop_reg;
        req_next      = req_reg;
        item_next     = item_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_last_next   = m_last_reg;
        cmd_pop       = 1'b0;
        store_we      = 1'b0;
        qrd_en        = 1'b0;

        case (state_reg)
            srb_pkg::ST_IDLE: begin
                if (!cmd_empty) begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd_data;
                    state_next = srb_pkg::ST_CHECK;
                end
            end
            srb_pkg::ST_CHECK: begin
                if (drop) begin
                    drop_next  = 1'b1;
                    state_next = srb_pkg::ST_IDLE;
                end else begin
                    store_we         = 1'b1;
                    valid_next[slot] = 1'b1;
                    pend_next        = pend_reg + 1'b1;
                    state_next       = c_flush ? srb_pkg::ST_RELEASE : srb_pkg::ST_IDLE;
                end
            end
            srb_pkg::ST_RELEASE: begin
                // One entry moves per cycle; its queue write follows in the next cycle, from mv_reg and srd_reg.
                if (valid_reg[ne_slot_reg] && (oc_reg < CntW'(CAPACITY))) begin
                    valid_next[ne_slot_reg] = 1'b0;
                    ne_next   = ne_reg + 1'b1;
                    pend_next = pend_reg - 1'b1;
                    oc_next   = oc_reg + 1'b1;
                    mv_next   = 1'b1;
                    if (tail_sum >= (IdxW + 1)'(CAPACITY)) begin
                        mv_addr_next = IdxW'(tail_sum - (IdxW + 1)'(CAPACITY));
                    end else begin
                        mv_addr_next = IdxW'(tail_sum);
                    end
                    if (ne_reg == '1 || ne_slot_reg == LastIdx) begin
                        ne_slot_next = '0;
                    end else begin
                        ne_slot_next = ne_slot_reg + 1'b1;
                    end
                end else begin
                    state_next = srb_pkg::ST_DECIDE;
                end
            end
            srb_pkg::ST_DECIDE: begin
                item_next     = (n_eff != '0);
                cnt_next      = n_eff;
                fs_next       = free_sel;
                req_next      = (oc_reg == '0);
                rep_drop_next = drop_reg;
                drop_next     = 1'b0;
                oc_next       = oc_reg - n_eff;
                state_next    = (n_eff != '0) ? srb_pkg::ST_READ : srb_pkg::ST_EMIT;
            end
            srb_pkg::ST_READ: begin
                qrd_en     = 1'b1;
                head_next  = (head_sum >= (IdxW + 1)'(CAPACITY)) ? '0 : IdxW'(head_sum);
                cnt_next   = cnt_reg - 1'b1;
                state_next = srb_pkg::ST_EMIT;
            end
            srb_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_user_next  = item_reg;
                    m_last_next  = is_last;
                    m_data_next  = '0;
                    if (item_reg) begin
                        m_data_next[SeqW-1:0] = q_seq;
                        m_data_next[SeqW +: srb_pkg::PayloadW] = srb_pkg::PayloadW'(q_data);
                        m_data_next[srb_pkg::ReqBit] = is_last;
                    end else begin
                        m_data_next[srb_pkg::ReqBit] = req_reg;
                    end
                    m_data_next[srb_pkg::DropBit] = is_last && rep_drop_reg;
                    m_data_next[srb_pkg::FreeLo +: srb_pkg::FreeW] = srb_pkg::FreeW'(fs_reg);
                    state_next = is_last ? srb_pkg::ST_IDLE : srb_pkg::ST_READ;
                end
            end
            default: begin
                state_next = srb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srb_pkg::ST_IDLE;
            valid_reg   <= '0;
            ne_reg      <= '0;
            ne_slot_reg <= '0;
            pend_reg    <= '0;
            oc_reg      <= '0;
            head_reg    <= '0;
            mv_reg      <= 1'b0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            ne_reg      <= ne_next;
            ne_slot_reg <= ne_slot_next;
            pend_reg    <= pend_next;
            oc_reg      <= oc_next;
            head_reg    <= head_next;
            mv_reg      <= mv_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        cnt_reg      <= cnt_next;
        fs_reg       <= fs_next;
        mv_addr_reg  <= mv_addr_next;
        rep_drop_reg <= rep_drop_next;
        req_reg      <= req_next;
        item_reg     <= item_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
        m_last_reg   <= m_last_next;
    end

    // Reorder store: written on acceptance, read every cycle at the expected slot.
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[slot] <= {c_data, c_seq};
        end
        srd_reg <= store_mem[ne_slot_reg];
    end

    // Output queue: filled by the release pipeline, read at the head on delivery.
    always_ff @(posedge aclk) begin
        if (mv_reg) begin
            queue_mem[mv_addr_reg] <= srd_reg;
        end
        if (qrd_en) begin
            qrd_reg <= queue_mem[head_reg];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule
